@@ rtl/frwq_pkg.sv @@
// Shared types and constants of the fit-release waiting queue.
`timescale 1ns / 1ps

package frwq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int TAG_W  = 16;
	localparam int SIZE_W = 8;
	localparam int CAP_W  = 12;

	localparam int CQ_DEPTH = 2;
	localparam int CQ_IW    = $clog2(CQ_DEPTH);
	localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_APPENDED = 3'd0,
		ST_FULL     = 3'd1,
		ST_ZERO     = 3'd2,
		ST_REMOVED  = 3'd3,
		ST_NONE_FIT = 3'd4,
		ST_EMPTY    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		CMD_APPEND,
		CMD_ZERO,
		CMD_RELEASE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [TAG_W-1:0]    tag;
		logic [SIZE_W-1:0]   size;
		logic [CAP_W-1:0]    capacity;
	} cmd_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [SIZE_W-1:0] size;
	} entry_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_port_t;

endpackage

@@ rtl/frwq_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module frwq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/frwq_front.sv @@
// Front end: accepts input beats, classifies them and buffers them in a short command queue.
`timescale 1ns / 1ps

module frwq_front import frwq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              mode,
	input  logic [TAG_W-1:0]  tag,
	input  logic [SIZE_W-1:0] group_size,
	input  logic [CAP_W-1:0]  capacity,
	output logic              busy,
	output cmd_port_t         cmd_out,
	input  logic              pop
);

	cmd_t             mem_q [CQ_DEPTH];
	logic [CQ_IW-1:0] wp_q;
	logic [CQ_IW-1:0] rp_q;
	logic [CQ_CW-1:0] fill_q;
	logic             push;
	logic             do_pop;
	cmd_t             cmd_new;

	assign busy   = (fill_q == CQ_CW'(CQ_DEPTH));
	assign push   = start && !busy;
	assign do_pop = pop && (fill_q != '0);

	// A zero size is refused no matter what the queue holds, so it is sorted out here.
	always_comb begin
		cmd_new.tag      = tag;
		cmd_new.size     = group_size;
		cmd_new.capacity = capacity;
		if (mode) begin
			cmd_new.kind = CMD_RELEASE;
		end else if (group_size == '0) begin
			cmd_new.kind = CMD_ZERO;
		end else begin
			cmd_new.kind = CMD_APPEND;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= cmd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == CQ_IW'(CQ_DEPTH - 1)) ? '0 : wp_q + CQ_IW'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == CQ_IW'(CQ_DEPTH - 1)) ? '0 : rp_q + CQ_IW'(1);
			end
			if (push && !do_pop) begin
				fill_q <= fill_q + CQ_CW'(1);
			end else if (do_pop && !push) begin
				fill_q <= fill_q - CQ_CW'(1);
			end
		end
	end

	assign cmd_out.valid = (fill_q != '0);
	assign cmd_out.cmd   = mem_q[rp_q];

endmodule

@@ rtl/frwq_back.sv @@
// Back end: executes appends and release walks over the entry RAM and drives result beats.
`timescale 1ns / 1ps

module frwq_back import frwq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_port_t         cmd_in,
	output logic              pop,
	output logic              done,
	output logic [2:0]        status,
	output logic [TAG_W-1:0]  out_tag,
	output logic [SIZE_W-1:0] out_size,
	output logic              last
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FLUSH
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  rd_q;
	logic [CNT_W-1:0]  wr_q;
	logic [CAP_W-1:0]  rem_q;
	logic              pend_q;
	entry_t            pend_entry_q;
	logic              done_q;
	status_t           status_q;
	logic [TAG_W-1:0]  tag_q;
	logic [SIZE_W-1:0] size_q;
	logic              last_q;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	entry_t            ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	entry_t            ram_rdata;
	logic              fits;
	logic              rd_last;
	logic              is_full;

	frwq_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign pop     = (state_q == S_IDLE) && cmd_in.valid;
	assign is_full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign fits    = {{(CAP_W - SIZE_W){1'b0}}, ram_rdata.size} <= rem_q;
	assign rd_last = (CNT_W'(rd_q) == count_q - CNT_W'(1));

	// The read for the first entry goes out as the release is taken; each walk cycle
	// then asks for the next one. Kept entries are written back below the read point.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_q[IDX_W-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = (state_q == S_WALK) ? rd_q + IDX_W'(1) : '0;
		if (state_q == S_WALK) begin
			ram_we = !fits;
		end else if (pop && cmd_in.cmd.kind == CMD_APPEND && !is_full) begin
			ram_we         = 1'b1;
			ram_waddr      = count_q[IDX_W-1:0];
			ram_wdata.tag  = cmd_in.cmd.tag;
			ram_wdata.size = cmd_in.cmd.size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			rd_q         <= '0;
			wr_q         <= '0;
			rem_q        <= '0;
			pend_q       <= 1'b0;
			pend_entry_q <= '0;
			done_q       <= 1'b0;
			status_q     <= ST_APPENDED;
			tag_q        <= '0;
			size_q       <= '0;
			last_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			tag_q  <= '0;
			size_q <= '0;
			last_q <= 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_in.valid) begin
						unique case (cmd_in.cmd.kind)
							CMD_APPEND, CMD_ZERO: begin
								done_q <= 1'b1;
								if (is_full) begin
									status_q <= ST_FULL;
								end else if (cmd_in.cmd.kind == CMD_ZERO) begin
									status_q <= ST_ZERO;
								end else begin
									status_q <= ST_APPENDED;
									count_q  <= count_q + CNT_W'(1);
								end
							end
							CMD_RELEASE: begin
								if (count_q == '0) begin
									done_q   <= 1'b1;
									status_q <= ST_EMPTY;
								end else begin
									rem_q   <= cmd_in.cmd.capacity;
									rd_q    <= '0;
									wr_q    <= '0;
									pend_q  <= 1'b0;
									state_q <= S_WALK;
								end
							end
							default: begin
								done_q   <= 1'b1;
								status_q <= ST_ZERO;
							end
						endcase
					end
				end
				S_WALK: begin
					// One removed entry is held back so that the final one can carry last.
					if (fits) begin
						rem_q        <= rem_q - CAP_W'(ram_rdata.size);
						pend_q       <= 1'b1;
						pend_entry_q <= ram_rdata;
						if (pend_q) begin
							done_q   <= 1'b1;
							status_q <= ST_REMOVED;
							tag_q    <= pend_entry_q.tag;
							size_q   <= pend_entry_q.size;
							last_q   <= 1'b0;
						end
					end else begin
						wr_q <= wr_q + CNT_W'(1);
					end
					if (rd_last) begin
						count_q <= fits ? wr_q : wr_q + CNT_W'(1);
						state_q <= S_FLUSH;
					end else begin
						rd_q <= rd_q + IDX_W'(1);
					end
				end
				S_FLUSH: begin
					done_q <= 1'b1;
					if (pend_q) begin
						status_q <= ST_REMOVED;
						tag_q    <= pend_entry_q.tag;
						size_q   <= pend_entry_q.size;
					end else begin
						status_q <= ST_NONE_FIT;
					end
					pend_q  <= 1'b0;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done     = done_q;
	assign status   = status_q;
	assign out_tag  = tag_q;
	assign out_size = size_q;
	assign last     = last_q;

endmodule

@@ rtl/fit_release_waiting_queue_core.sv @@
// Top level of the fit-release waiting queue: front end, command queue and back end.
// An append or an empty release gives a registered result beat once the back end takes it;
// a release gives its last beat after a walk over all stored entries and a flush step, later
// if earlier work is queued. Appends sustain one beat per cycle while no release holds the
// back end; a release holds it for its walk, one RAM read per entry. Results cannot be stalled.
// Reset (arst_n low, asynchronous) empties the queue and the command buffer; RAM contents stay.
`timescale 1ns / 1ps

module fit_release_waiting_queue_core import frwq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              mode,
	input  logic [TAG_W-1:0]  tag,
	input  logic [SIZE_W-1:0] group_size,
	input  logic [CAP_W-1:0]  capacity,
	output logic              done,
	output logic [2:0]        status,
	output logic [TAG_W-1:0]  out_tag,
	output logic [SIZE_W-1:0] out_size,
	output logic              last
);

	// The front end takes a beat whenever its two-entry command buffer has room. A zero
	// size append is marked there; whether the queue is full is only known to the back end,
	// since a release that is still ahead in the buffer may free entries.
	cmd_port_t cmd;
	logic      pop;

	frwq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mode      (mode),
		.tag       (tag),
		.group_size(group_size),
		.capacity  (capacity),
		.busy      (busy),
		.cmd_out   (cmd),
		.pop       (pop)
	);

	// The back end owns the entry RAM and the entry count. A release walks the entries
	// oldest first, one per cycle, reports each one that fits the remaining capacity and
	// writes the others back in order, which closes the gaps. The last removed entry is
	// reported in a final flush cycle, or a none-fit beat is given there instead.
	frwq_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_in  (cmd),
		.pop     (pop),
		.done    (done),
		.status  (status),
		.out_tag (out_tag),
		.out_size(out_size),
		.last    (last)
	);

`ifndef SYNTHESIS
	// Busy can only rise because a beat was just taken into the command buffer.
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without an accepted beat");

	// Every result other than a removed entry is the only one of its item.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_REMOVED) |-> last)
		else $error("single result without last");

	// Only removed entries carry a tag and a size.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_REMOVED) |-> (out_tag == '0 && out_size == '0))
		else $error("non-removal result carries entry fields");

	// Zero sizes are never stored, so a removed entry always has a size.
	a_removed_size: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_REMOVED) |-> (out_size != '0))
		else $error("removed entry with zero size");
`endif

endmodule
